@@ rtl/scse_pkg.sv @@
// Package for the square channel with sweep and envelope.
// Holds constants, codes and the duty table; depends on nothing.
`default_nettype none
package scse_pkg;
  localparam int LENGTH_MAX = 64;
  localparam int SEQ_DIVIDE = 2048;
  localparam int LEN_W = $clog2(LENGTH_MAX + 1);
  localparam int SUB_W = $clog2(SEQ_DIVIDE + 1);

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0, MODE_EVENT = 2'd1, MODE_WRITE = 2'd2, MODE_READ = 2'd3
  } mode_t;

  localparam logic [1:0] EV_LENGTH = 2'd0;
  localparam logic [1:0] EV_LEN_SWEEP = 2'd1;
  localparam logic [1:0] EV_ENVELOPE = 2'd2;

  localparam logic [2:0] REG_SWEEP = 3'd0;
  localparam logic [2:0] REG_LEN_DUTY = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_PERIOD_LO = 3'd3;
  localparam logic [2:0] REG_CONTROL = 3'd4;

  localparam logic [0:0] CFG_HAS_SWEEP = 1'd0;
  localparam logic [0:0] CFG_USE_SEQ = 1'd1;

  // duty waveforms, bit i is step i
  function automatic logic duty_lookup(input logic [1:0] sel, input logic [2:0] idx);
    logic [7:0] w;
    begin
      unique case (sel)
        2'd0: w = 8'b1000_0000;
        2'd1: w = 8'b1000_0001;
        2'd2: w = 8'b1110_0001;
        default: w = 8'b0111_1110;
      endcase
      duty_lookup = w[idx];
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/scse_stream_if.sv @@
// Valid/ready stream interfaces for input items, results and config writes.
// Depends on nothing.
`default_nettype none
interface scse_in_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] frame_event;
  logic [2:0] reg_index;
  logic [7:0] write_data;
  modport source (output valid, mode, frame_event, reg_index, write_data, input ready);
  modport sink (input valid, mode, frame_event, reg_index, write_data, output ready);
endinterface

interface scse_out_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [3:0] sample_out;
  logic       sample_updated;
  logic       channel_on;
  logic [7:0] read_data;
  modport source (output valid, sample_out, sample_updated, channel_on, read_data,
                  input ready);
  modport sink (input valid, sample_out, sample_updated, channel_on, read_data,
                output ready);
endinterface

interface scse_cfg_if (input wire logic clk);
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/square_channel_sweep_envelope.sv @@
// Square channel: registered results, one item per cycle while input ready is high.
// A two-entry skid buffer on the result side keeps input ready high while one
// result waits; ready drops only when both entries are full.
// Reset (rst_n low, synchronous) clears all channel state and configuration.
// Depends on scse_pkg and the stream interfaces.
`default_nettype none
module square_channel_sweep_envelope
  import scse_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  scse_in_if.sink   in_ch,
  scse_out_if.source out_ch,
  scse_cfg_if.sink  cfg_ch
);
  typedef struct packed {
    logic [3:0] sample;
    logic       updated;
    logic       on;
    logic [7:0] rd;
  } res_t;

  logic has_sweep_r, use_seq_r;
  logic [11:0] period_count_r;
  logic [7:0] period_low_r;
  logic [2:0] period_high_r;
  logic [1:0] duty_select_r;
  logic [2:0] step_index_r;
  logic duty_bit_r;
  logic [3:0] volume_r, env_start_r;
  logic env_rising_r;
  logic [2:0] env_pace_r, env_count_r;
  logic [2:0] sweep_pace_r, sweep_shift_r;
  logic sweep_down_r;
  logic [7:0] sweep_count_r;
  logic [10:0] shadow_r;
  logic sweep_active_r, sub_done_r;
  logic [LEN_W-1:0] length_count_r;
  logic length_enable_r, enabled_r, dac_on_r;
  logic [3:0] level_r;
  logic [SUB_W-1:0] subtick_r;
  logic [2:0] seq_step_r;

  // next-state copies
  logic [11:0] period_count_nxt;
  logic [7:0] period_low_nxt;
  logic [2:0] period_high_nxt;
  logic [1:0] duty_select_nxt;
  logic [2:0] step_index_nxt;
  logic duty_bit_nxt;
  logic [3:0] volume_nxt, env_start_nxt;
  logic env_rising_nxt;
  logic [2:0] env_pace_nxt, env_count_nxt;
  logic [2:0] sweep_pace_nxt, sweep_shift_nxt;
  logic sweep_down_nxt;
  logic [7:0] sweep_count_nxt;
  logic [10:0] shadow_nxt;
  logic sweep_active_nxt, sub_done_nxt;
  logic [LEN_W-1:0] length_count_nxt;
  logic length_enable_nxt, enabled_nxt, dac_on_nxt;
  logic [3:0] level_nxt;
  logic [SUB_W-1:0] subtick_nxt;
  logic [2:0] seq_step_nxt;
  res_t res_nxt;

  // skid buffer
  res_t buf0_r, buf1_r;
  logic [1:0] cnt_r;
  logic in_xfer, out_xfer;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.sample_out = buf0_r.sample;
  assign out_ch.sample_updated = buf0_r.updated;
  assign out_ch.channel_on = buf0_r.on;
  assign out_ch.read_data = buf0_r.rd;

  // channel update for one item
  always_comb begin
    logic [11:0] full;
    logic [11:0] pc_inc;
    logic [11:0] nxt1, nxt2;
    logic do_len, do_sweep, do_env, upd, trig;
    logic [7:0] v;
    logic [5:0] ld;
    full = {1'b0, period_high_r, period_low_r};
    period_count_nxt = period_count_r; period_low_nxt = period_low_r;
    period_high_nxt = period_high_r; duty_select_nxt = duty_select_r;
    step_index_nxt = step_index_r; duty_bit_nxt = duty_bit_r;
    volume_nxt = volume_r; env_start_nxt = env_start_r; env_rising_nxt = env_rising_r;
    env_pace_nxt = env_pace_r; env_count_nxt = env_count_r;
    sweep_pace_nxt = sweep_pace_r; sweep_shift_nxt = sweep_shift_r;
    sweep_down_nxt = sweep_down_r; sweep_count_nxt = sweep_count_r;
    shadow_nxt = shadow_r; sweep_active_nxt = sweep_active_r; sub_done_nxt = sub_done_r;
    length_count_nxt = length_count_r; length_enable_nxt = length_enable_r;
    enabled_nxt = enabled_r; dac_on_nxt = dac_on_r; level_nxt = level_r;
    subtick_nxt = subtick_r; seq_step_nxt = seq_step_r;
    do_len = 1'b0; do_sweep = 1'b0; do_env = 1'b0; upd = 1'b0; trig = 1'b0;
    v = in_ch.write_data; ld = v[5:0];
    nxt1 = 12'd0; nxt2 = 12'd0; pc_inc = period_count_r + 12'd1;
    res_nxt.rd = 8'h00;

    unique case (mode_t'(in_ch.mode))
      MODE_TICK: begin
        if (pc_inc[11]) begin
          period_count_nxt = full;
          step_index_nxt = step_index_r + 3'd1;
          duty_bit_nxt = duty_lookup(duty_select_r, step_index_nxt);
          upd = 1'b1;
        end else begin
          period_count_nxt = pc_inc;
        end
        if (use_seq_r) begin
          if (subtick_r + SUB_W'(1) >= SUB_W'(SEQ_DIVIDE)) begin
            subtick_nxt = '0;
            seq_step_nxt = seq_step_r + 3'd1;
            unique case (seq_step_r)
              3'd0, 3'd4: do_len = 1'b1;
              3'd2, 3'd6: begin do_len = 1'b1; do_sweep = 1'b1; end
              3'd7: do_env = 1'b1;
              default: ;
            endcase
          end else begin
            subtick_nxt = subtick_r + SUB_W'(1);
          end
        end
      end
      MODE_EVENT: begin
        unique case (in_ch.frame_event)
          EV_LENGTH: do_len = 1'b1;
          EV_LEN_SWEEP: begin do_len = 1'b1; do_sweep = 1'b1; end
          EV_ENVELOPE: do_env = 1'b1;
          default: ;
        endcase
      end
      MODE_WRITE: begin
        unique case (in_ch.reg_index)
          REG_SWEEP: begin
            if (!has_sweep_r) v = 8'h00;
            sweep_shift_nxt = v[2:0]; sweep_down_nxt = v[3]; sweep_pace_nxt = v[6:4];
            if (!v[3] && sweep_down_r && sub_done_r) enabled_nxt = 1'b0;
          end
          REG_LEN_DUTY: begin
            if (32'(ld) > LENGTH_MAX) length_count_nxt = '0;
            else length_count_nxt = LEN_W'(LENGTH_MAX - 32'(ld));
            duty_select_nxt = v[7:6];
          end
          REG_ENVELOPE: begin
            env_pace_nxt = v[2:0]; env_rising_nxt = v[3]; env_start_nxt = v[7:4];
            dac_on_nxt = (v[7:3] != 5'd0);
            if (v[7:3] == 5'd0) enabled_nxt = 1'b0;
          end
          REG_PERIOD_LO: period_low_nxt = v;
          REG_CONTROL: begin
            length_enable_nxt = v[6]; period_high_nxt = v[2:0];
            trig = v[7];
          end
          default: ;
        endcase
      end
      default: begin
        unique case (in_ch.reg_index)
          REG_SWEEP: res_nxt.rd = has_sweep_r ?
              {1'b1, sweep_pace_r, sweep_down_r, sweep_shift_r} : 8'hFF;
          REG_LEN_DUTY: res_nxt.rd = {duty_select_r, 6'd0};
          REG_ENVELOPE: res_nxt.rd = {env_start_r, env_rising_r, env_pace_r};
          REG_CONTROL: res_nxt.rd = {1'b0, length_enable_r, 6'd0};
          default: res_nxt.rd = 8'hFF;
        endcase
      end
    endcase

    // length timer
    if (do_len && length_enable_r && length_count_r != '0) begin
      length_count_nxt = length_count_r - LEN_W'(1);
      if (length_count_r == LEN_W'(1)) enabled_nxt = 1'b0;
    end
    // frequency sweep
    if (do_sweep && has_sweep_r) begin
      sweep_count_nxt = sweep_count_r - 8'd1;
      if (sweep_count_nxt == 8'd0) begin
        sweep_count_nxt = (sweep_pace_r == 3'd0) ? 8'd8 : {5'd0, sweep_pace_r};
        if (sweep_active_r && sweep_pace_r != 3'd0) begin
          nxt1 = sweep_down_r ? {1'b0, shadow_r} - {1'b0, shadow_r >> sweep_shift_r}
                              : {1'b0, shadow_r} + {1'b0, shadow_r >> sweep_shift_r};
          if (sweep_down_r) sub_done_nxt = 1'b1;
          if (nxt1 > 12'h7FF) begin
            enabled_nxt = 1'b0; sweep_active_nxt = 1'b0;
          end else if (sweep_shift_r != 3'd0) begin
            shadow_nxt = nxt1[10:0];
            period_low_nxt = nxt1[7:0]; period_high_nxt = nxt1[10:8];
            nxt2 = sweep_down_r ? nxt1 - {1'b0, nxt1[10:0] >> sweep_shift_r}
                                : nxt1 + {1'b0, nxt1[10:0] >> sweep_shift_r};
            if (nxt2 > 12'h7FF) begin
              enabled_nxt = 1'b0; sweep_active_nxt = 1'b0;
            end
          end
        end
      end
    end
    // envelope
    if (do_env && env_pace_r != 3'd0) begin
      env_count_nxt = env_count_r + 3'd1;
      if (env_count_nxt == env_pace_r) begin
        env_count_nxt = 3'd0;
        if (env_rising_r) begin
          if (volume_r != 4'd15) volume_nxt = volume_r + 4'd1;
        end else if (volume_r != 4'd0) begin
          volume_nxt = volume_r - 4'd1;
        end
      end
    end
    // trigger uses the period just written
    if (trig) begin
      full = {1'b0, v[2:0], period_low_r};
      if (length_count_r == '0) length_count_nxt = LEN_W'(LENGTH_MAX);
      if (dac_on_r) enabled_nxt = 1'b1;
      duty_bit_nxt = 1'b0;
      period_count_nxt = full;
      volume_nxt = env_start_r;
      env_count_nxt = 3'd0;
      shadow_nxt = full[10:0];
      sweep_count_nxt = (sweep_pace_r == 3'd0) ? 8'd8 : {5'd0, sweep_pace_r};
      sweep_active_nxt = (sweep_pace_r != 3'd0) || (sweep_shift_r != 3'd0);
      // the overflow check only runs, and only counts as a subtraction, with a nonzero shift
      sub_done_nxt = sweep_down_r && (sweep_shift_r != 3'd0);
      nxt1 = sweep_down_r ? full - {1'b0, full[10:0] >> sweep_shift_r}
                          : full + {1'b0, full[10:0] >> sweep_shift_r};
      if (sweep_shift_r != 3'd0 && nxt1 > 12'h7FF) begin
        enabled_nxt = 1'b0; sweep_active_nxt = 1'b0;
      end
    end
    if (upd)
      level_nxt = dac_on_nxt ? ((enabled_nxt && duty_bit_nxt) ? volume_nxt : 4'd0) : 4'd7;

    res_nxt.sample = level_nxt;
    res_nxt.updated = upd;
    res_nxt.on = enabled_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_sweep_r <= 1'b0; use_seq_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_HAS_SWEEP) has_sweep_r <= cfg_ch.data[0];
      if (cfg_ch.index == CFG_USE_SEQ) use_seq_r <= cfg_ch.data[0];
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r <= '0; period_low_r <= '0; period_high_r <= '0;
      duty_select_r <= '0; step_index_r <= '0; duty_bit_r <= 1'b0;
      volume_r <= '0; env_start_r <= '0; env_rising_r <= 1'b0;
      env_pace_r <= '0; env_count_r <= '0; sweep_pace_r <= '0;
      sweep_shift_r <= '0; sweep_down_r <= 1'b0; sweep_count_r <= '0;
      shadow_r <= '0; sweep_active_r <= 1'b0; sub_done_r <= 1'b0;
      length_count_r <= '0; length_enable_r <= 1'b0; enabled_r <= 1'b0;
      dac_on_r <= 1'b0; level_r <= '0; subtick_r <= '0; seq_step_r <= '0;
    end else if (in_xfer) begin
      period_count_r <= period_count_nxt; period_low_r <= period_low_nxt;
      period_high_r <= period_high_nxt; duty_select_r <= duty_select_nxt;
      step_index_r <= step_index_nxt; duty_bit_r <= duty_bit_nxt;
      volume_r <= volume_nxt; env_start_r <= env_start_nxt;
      env_rising_r <= env_rising_nxt; env_pace_r <= env_pace_nxt;
      env_count_r <= env_count_nxt; sweep_pace_r <= sweep_pace_nxt;
      sweep_shift_r <= sweep_shift_nxt; sweep_down_r <= sweep_down_nxt;
      sweep_count_r <= sweep_count_nxt; shadow_r <= shadow_nxt;
      sweep_active_r <= sweep_active_nxt; sub_done_r <= sub_done_nxt;
      length_count_r <= length_count_nxt; length_enable_r <= length_enable_nxt;
      enabled_r <= enabled_nxt; dac_on_r <= dac_on_nxt; level_r <= level_nxt;
      subtick_r <= subtick_nxt; seq_step_r <= seq_step_nxt;
    end
  end

  // result skid buffer: buf0 is the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      buf0_r <= (cnt_r == 2'd2) ? buf1_r : res_nxt;
    end else if (in_xfer && cnt_r == 2'd0) begin
      buf0_r <= res_nxt;
    end
    if (in_xfer && (cnt_r == 2'd1 && !out_xfer || cnt_r == 2'd2)) buf1_r <= res_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/scse_checker.sv @@
// Port-level checker for the square channel, bound to the top level.
// Depends on scse_pkg and the stream interfaces.
`default_nettype none
module scse_checker
  import scse_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [1:0] in_mode,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [3:0] sample_out,
  input wire logic [7:0] read_data
);
  // after every input transfer, a result is valid in the next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("missing result");
  // with the result side free, input is never stalled
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready) else $error("input stalled");
  // writes return zero read data
  a_rd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_WRITE && !out_valid |=> read_data == 8'h00)
    else $error("read data on write");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(sample_out)) else $error("result changed");
endmodule

bind square_channel_sweep_envelope scse_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_mode(in_ch.mode), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .sample_out(out_ch.sample_out), .read_data(out_ch.read_data)
);
`default_nettype wire

@@ dv/tb_top.sv @@
// Testbench for square_channel_sweep_envelope: directed and random items checked
// against an in-bench channel predictor. Depends on scse_pkg and the stream interfaces.
module tb_top
  import scse_pkg::*;
();

  typedef struct packed {
    logic [3:0] sample_out;
    logic       sample_updated;
    logic       channel_on;
    logic [7:0] read_data;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scse_in_if  in_if (clk);
  scse_out_if out_if (clk);
  scse_cfg_if cfg_if (clk);

  square_channel_sweep_envelope u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source), .cfg_ch(cfg_if.sink)
  );

  // channel shadow state
  logic        cf_sweep, cf_seq;
  logic [11:0] p_count;
  logic [7:0]  p_low;
  logic [2:0]  p_high;
  logic [1:0]  duty_sel;
  logic [2:0]  step_idx;
  logic        duty_b;
  logic [3:0]  vol, env_vol0;
  logic        env_up;
  logic [2:0]  env_pace_r, env_cnt;
  logic [2:0]  sw_pace, sw_shift;
  logic        sw_down, sw_active, sub_seen;
  logic [7:0]  sw_cnt;
  logic [10:0] shadow_p;
  logic [6:0]  len_cnt;
  logic        len_en, chan_en, dac_en;
  logic [3:0]  level_r;
  logic [11:0] seq_sub;
  logic [2:0]  seq_pos;

  sample_t expected_samples[$];
  int errors = 0, mismatches = 0, n_in = 0, n_out = 0, n_upd = 0;
  int stall_hold = 0;
  bit steady = 0;
  int cycle = 0;

  function automatic logic [11:0] sweep_next();
    logic [11:0] d;
    d = {1'b0, shadow_p} >> sw_shift;
    if (sw_down) begin
      sub_seen = 1'b1;
      return {1'b0, shadow_p} - d;
    end
    return {1'b0, shadow_p} + d;
  endfunction

  function automatic void len_step();
    if (len_en && len_cnt > 0) begin
      len_cnt = len_cnt - 1;
      if (len_cnt == 0) chan_en = 1'b0;
    end
  endfunction

  function automatic void sweep_step();
    logic [11:0] nx;
    if (!cf_sweep) return;
    sw_cnt = sw_cnt - 8'd1;
    if (sw_cnt != 0) return;
    sw_cnt = (sw_pace == 0) ? 8'd8 : {5'd0, sw_pace};
    if (!sw_active || sw_pace == 0) return;
    nx = sweep_next();
    if (nx > 12'h7FF) begin
      chan_en = 1'b0;
      sw_active = 1'b0;
      return;
    end
    if (sw_shift != 0) begin
      shadow_p = nx[10:0];
      p_low = nx[7:0];
      p_high = nx[10:8];
      if (sweep_next() > 12'h7FF) begin
        chan_en = 1'b0;
        sw_active = 1'b0;
      end
    end
  endfunction

  function automatic void env_step();
    if (env_pace_r == 0) return;
    env_cnt = env_cnt + 3'd1;
    if (env_cnt == env_pace_r) begin
      env_cnt = 0;
      if (env_up) begin
        if (vol < 15) vol = vol + 1;
      end else if (vol > 0) begin
        vol = vol - 1;
      end
    end
  endfunction

  function automatic void reg_write(logic [2:0] idx, logic [7:0] v);
    logic old_down;
    case (idx)
      REG_SWEEP: begin
        if (!cf_sweep) v = 8'd0;
        old_down = sw_down;
        sw_shift = v[2:0];
        sw_down = v[3];
        sw_pace = v[6:4];
        if (!sw_down && old_down && sub_seen) chan_en = 1'b0;
      end
      REG_LEN_DUTY: begin
        len_cnt = 7'(LENGTH_MAX - int'(v[5:0]));
        duty_sel = v[7:6];
      end
      REG_ENVELOPE: begin
        env_pace_r = v[2:0];
        env_up = v[3];
        env_vol0 = v[7:4];
        dac_en = v[7:3] != 0;
        if (!dac_en) chan_en = 1'b0;
      end
      REG_PERIOD_LO: p_low = v;
      REG_CONTROL: begin
        len_en = v[6];
        p_high = v[2:0];
        if (v[7]) begin
          // trigger
          if (len_cnt == 0) len_cnt = 7'(LENGTH_MAX);
          if (dac_en) chan_en = 1'b1;
          duty_b = 1'b0;
          p_count = {1'b0, p_high, p_low};
          vol = env_vol0;
          env_cnt = 0;
          shadow_p = {p_high, p_low};
          sw_cnt = (sw_pace == 0) ? 8'd8 : {5'd0, sw_pace};
          sw_active = (sw_pace > 0) || (sw_shift > 0);
          sub_seen = 1'b0;
          if (sw_shift != 0 && sweep_next() > 12'h7FF) begin
            chan_en = 1'b0;
            sw_active = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] reg_read(logic [2:0] idx);
    case (idx)
      REG_SWEEP: return cf_sweep ? {1'b1, sw_pace, sw_down, sw_shift} : 8'hFF;
      REG_LEN_DUTY: return {duty_sel, 6'd0};
      REG_ENVELOPE: return {env_vol0, env_up, env_pace_r};
      REG_CONTROL: return {1'b0, len_en, 6'd0};
      default: return 8'hFF;
    endcase
  endfunction

  function automatic sample_t channel_step(logic [1:0] md, logic [1:0] ev, logic [2:0] idx,
                                           logic [7:0] wd);
    sample_t r;
    logic upd;
    logic [7:0] rd;
    upd = 1'b0;
    rd = 8'd0;
    case (mode_t'(md))
      MODE_TICK: begin
        p_count = p_count + 12'd1;
        if (p_count >= 12'd2048) begin
          p_count = {1'b0, p_high, p_low};
          step_idx = step_idx + 3'd1;
          duty_b = duty_lookup(duty_sel, step_idx);
          upd = 1'b1;
        end
        if (cf_seq) begin
          seq_sub = seq_sub + 12'd1;
          if (seq_sub >= 12'(SEQ_DIVIDE)) begin
            seq_sub = 0;
            if (seq_pos == 0 || seq_pos == 4) len_step();
            else if (seq_pos == 2 || seq_pos == 6) begin
              len_step();
              sweep_step();
            end else if (seq_pos == 7) env_step();
            seq_pos = seq_pos + 3'd1;
          end
        end
        if (upd) level_r = dac_en ? (chan_en && duty_b ? vol : 4'd0) : 4'd7;
      end
      MODE_EVENT: begin
        if (ev == EV_LENGTH) len_step();
        else if (ev == EV_LEN_SWEEP) begin
          len_step();
          sweep_step();
        end else if (ev == EV_ENVELOPE) env_step();
      end
      MODE_WRITE: reg_write(idx, wd);
      default: rd = reg_read(idx);
    endcase
    r.sample_out = level_r;
    r.sample_updated = upd;
    r.channel_on = chan_en;
    r.read_data = rd;
    return r;
  endfunction

  // monitor: check result transfers, then predict accepted inputs
  always @(posedge clk) begin
    sample_t got, exp_s;
    cycle <= cycle + 1;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.sample_out, out_if.sample_updated, out_if.channel_on, out_if.read_data};
        n_out++;
        if (got.sample_updated) n_upd++;
        if (expected_samples.size() == 0) begin
          errors++;
          $display("unexpected result transfer %h", got);
        end else begin
          exp_s = expected_samples.pop_front();
          if (got != exp_s) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp out=%0d upd=%0b on=%0b rd=%h, got out=%0d upd=%0b on=%0b rd=%h",
                       n_out, exp_s.sample_out, exp_s.sample_updated, exp_s.channel_on,
                       exp_s.read_data, got.sample_out, got.sample_updated, got.channel_on,
                       got.read_data);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        n_in++;
        expected_samples.push_back(channel_step(in_if.mode, in_if.frame_event, in_if.reg_index,
                                                in_if.write_data));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_HAS_SWEEP) cf_sweep <= cfg_if.data[0];
        else cf_seq <= cfg_if.data[0];
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle > 600000) begin
      $display("timeout after %0d cycles", cycle);
      $display("square_channel_sweep_envelope regression: fail");
      $finish;
    end
  end

  // result sink with random stalls and an optional long hold-off
  initial begin
    int s;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall_hold) @(posedge clk);
        stall_hold = 0;
      end else begin
        s = steady ? 0 : $urandom_range(0, 4);
        if (s > 0) begin
          out_if.ready <= 1'b0;
          repeat (s) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  task automatic send_item(logic [1:0] md, logic [1:0] ev, logic [2:0] idx, logic [7:0] wd);
    int g;
    g = steady ? 0 : $urandom_range(0, 4);
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= md;
    in_if.frame_event <= ev;
    in_if.reg_index <= idx;
    in_if.write_data <= wd;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wr(logic [2:0] idx, logic [7:0] v);
    send_item(MODE_WRITE, 2'd0, idx, v);
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(MODE_TICK, 2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // sender pause until every expected result is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_cfg(logic sweep_on, logic seq_on);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_HAS_SWEEP;
    cfg_if.data <= {7'd0, sweep_on};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_USE_SEQ;
    cfg_if.data <= {7'($urandom) << 1, seq_on};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed();
    int i;
    set_cfg(1'b1, 1'b0);
    wr(REG_ENVELOPE, 8'hF3);
    wr(REG_LEN_DUTY, 8'hFF);
    wr(REG_PERIOD_LO, 8'hFE);
    wr(REG_CONTROL, 8'hC7);
    ticks(6);
    for (i = 0; i < 8; i++) send_item(MODE_READ, 2'd3, 3'(i), 8'hFF);
    for (i = 0; i < 4; i++) send_item(MODE_EVENT, 2'(i), 3'd7, 8'd0);
    // subtract sweep, then flip to add: channel drops
    wr(REG_SWEEP, 8'h19);
    wr(REG_CONTROL, 8'h87);
    send_item(MODE_EVENT, EV_LEN_SWEEP, 3'd0, 8'd0);
    wr(REG_SWEEP, 8'h11);
    wr(3'd6, 8'hAA);
    wr(REG_ENVELOPE, 8'h00);
  endtask

  task automatic test_sweep_overflow();
    // add sweep with large period overflows at the sweep event
    wr(REG_ENVELOPE, 8'hA8);
    wr(REG_SWEEP, 8'h71);
    wr(REG_PERIOD_LO, 8'h00);
    wr(REG_CONTROL, 8'h06);
    wr(REG_CONTROL, 8'h84);
    repeat (10) send_item(MODE_EVENT, EV_LEN_SWEEP, 3'd0, 8'd0);
    wr(REG_SWEEP, 8'h17);
    wr(REG_CONTROL, 8'h87);
  endtask

  task automatic test_no_sweep();
    set_cfg(1'b0, 1'b0);
    wr(REG_SWEEP, 8'hFF);
    send_item(MODE_READ, 2'd0, REG_SWEEP, 8'd0);
    wr(REG_ENVELOPE, 8'h5F);
    wr(REG_CONTROL, 8'h87);
    repeat (4) send_item(MODE_EVENT, EV_LEN_SWEEP, 3'd0, 8'd0);
    ticks(10);
  endtask

  task automatic test_internal_seq();
    set_cfg(1'b1, 1'b1);
    steady = 1;
    wr(REG_ENVELOPE, 8'h09);
    wr(REG_LEN_DUTY, 8'h7C);
    wr(REG_SWEEP, 8'h22);
    wr(REG_PERIOD_LO, 8'hF0);
    wr(REG_CONTROL, 8'hC7);
    ticks(40);
    steady = 0;
  endtask

  task automatic random_item();
    int r;
    logic [7:0] d;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    if (r < 50) ticks(1);
    else if (r < 65) send_item(MODE_EVENT, 2'($urandom), 3'($urandom), d);
    else if (r < 90) begin
      // keep periods near the top so duty steps come often
      if ($urandom_range(0, 3) == 0) wr(REG_PERIOD_LO, 8'($urandom_range(200, 255)));
      else if ($urandom_range(0, 2) == 0) wr(REG_CONTROL, {d[7:3], 3'd7});
      else wr(3'($urandom), d);
    end else send_item(MODE_READ, 2'($urandom), 3'($urandom), d);
  endtask

  task automatic test_random();
    int k, j;
    for (k = 0; k < 4; k++) begin
      set_cfg(k[0], k[1]);
      wr(REG_ENVELOPE, 8'($urandom) | 8'h80);
      wr(REG_CONTROL, 8'h87);
      for (j = 0; j < 120; j++) begin
        if (j % 40 == 0) steady = ($urandom_range(0, 1) == 1);
        random_item();
      end
      steady = 0;
    end
  endtask

  task automatic test_backpressure();
    steady = 1;
    stall_hold = 80;
    repeat (30) random_item();
    steady = 0;
    drain();
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_TICK;
    in_if.frame_event = 2'd0;
    in_if.reg_index = 3'd0;
    in_if.write_data = 8'd0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_HAS_SWEEP;
    cfg_if.data = 8'd0;
    {cf_sweep, cf_seq, p_count, p_low, p_high, duty_sel, step_idx, duty_b} = '0;
    {vol, env_vol0, env_up, env_pace_r, env_cnt, sw_pace, sw_shift} = '0;
    {sw_down, sw_active, sub_seen, sw_cnt, shadow_p, len_cnt, len_en} = '0;
    {chan_en, dac_en, level_r, seq_sub, seq_pos} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_sweep_overflow();
    test_no_sweep();
    test_internal_seq();
    test_random();
    test_backpressure();
    set_cfg(1'b1, 1'b1);

    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_samples.size() != 0) errors++;
    $display("ran %0d items, %0d results checked (%0d duty steps) over %0d cycles",
             n_in, n_out, n_upd, cycle);
    $display("covered register traffic, sweep, envelope, length, sequencer counting, stalls");
    if (errors == 0) begin
      $display("square_channel_sweep_envelope regression: pass");
    end else begin
      $display("%0d failures", errors);
      $display("square_channel_sweep_envelope regression: fail");
    end
    $finish;
  end
endmodule
